// ===== rtl/kntt_pkg.sv =====
package kntt_pkg;

   localparam int PolyLength = 256;
   localparam int AddrWidth  = 8;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [1:0] CSR_INVERSE_MODE = 2'd0;
   localparam logic [1:0] CSR_REDUCE_FWD   = 2'd1;

   localparam logic signed [31:0] MOD_Q         = 32'sd3329;
   localparam logic        [31:0] MOD_QINV      = 32'd62209;
   localparam logic signed [32:0] BARRETT_V     = 33'sd20159;
   localparam logic signed [32:0] BARRETT_ROUND = 33'sd33554432;
   localparam logic signed [15:0] INV_SCALE     = 16'sd1441;

   typedef enum logic [1:0] {
      OP_FWD = 2'd0,
      OP_INV = 2'd1,
      OP_RED = 2'd2,
      OP_SCL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      WS_REQ  = 3'd0,
      WS_SUM  = 3'd1,
      WS_DIFF = 3'd2,
      WS_BAR  = 3'd3,
      WS_MONT = 3'd4
   } wsel_type;

   typedef struct packed {
      logic           rd_en;
      logic [7:0]     rd_addr;
      logic           wr_en;
      logic [7:0]     wr_addr;
      wsel_type       wsel;
      op_type         op;
      logic [6:0]     rom_idx;
      logic           cap_a;
      logic           cap_b;
      logic           step1;
      logic           step2;
      logic           step3;
      logic           rsp_load;
   } cmd_type;

   localparam logic signed [15:0] TWIDDLE [128] = '{
      -16'sd1044,  -16'sd758,  -16'sd359, -16'sd1517,  16'sd1493,  16'sd1422,   16'sd287,
        16'sd202,
       -16'sd171,   16'sd622,  16'sd1577,   16'sd182,   16'sd962, -16'sd1202, -16'sd1474,
       16'sd1468,
        16'sd573, -16'sd1325,   16'sd264,   16'sd383,  -16'sd829,  16'sd1458, -16'sd1602,
       -16'sd130,
       -16'sd681,  16'sd1017,   16'sd732,   16'sd608, -16'sd1542,   16'sd411,  -16'sd205,
      -16'sd1571,
       16'sd1223,   16'sd652,  -16'sd552,  16'sd1015, -16'sd1293,  16'sd1491,  -16'sd282,
      -16'sd1544,
        16'sd516,    -16'sd8,  -16'sd320,  -16'sd666, -16'sd1618, -16'sd1162,   16'sd126,
       16'sd1469,
       -16'sd853,   -16'sd90,  -16'sd271,   16'sd830,   16'sd107, -16'sd1421,  -16'sd247,
       -16'sd951,
       -16'sd398,   16'sd961, -16'sd1508,  -16'sd725,   16'sd448, -16'sd1065,   16'sd677,
      -16'sd1275,
      -16'sd1103,   16'sd430,   16'sd555,   16'sd843, -16'sd1251,   16'sd871,  16'sd1550,
        16'sd105,
        16'sd422,   16'sd587,   16'sd177,  -16'sd235,  -16'sd291,  -16'sd460,  16'sd1574,
       16'sd1653,
       -16'sd246,   16'sd778,  16'sd1159,  -16'sd147,  -16'sd777,  16'sd1483,  -16'sd602,
       16'sd1119,
      -16'sd1590,   16'sd644,  -16'sd872,   16'sd349,   16'sd418,   16'sd329,  -16'sd156,
        -16'sd75,
        16'sd817,  16'sd1097,   16'sd603,   16'sd610,  16'sd1322, -16'sd1285, -16'sd1465,
        16'sd384,
      -16'sd1215,  -16'sd136,  16'sd1218, -16'sd1335,  -16'sd874,   16'sd220, -16'sd1187,
      -16'sd1659,
      -16'sd1185, -16'sd1530, -16'sd1278,   16'sd794, -16'sd1510,  -16'sd854,  -16'sd870,
        16'sd478,
       -16'sd108,  -16'sd308,   16'sd996,   16'sd991,   16'sd958, -16'sd1460,  16'sd1522,
       16'sd1628
   };

endpackage

// ===== rtl/kyber_ntt_forward_inverse.sv =====
// Number-theoretic transform engine for one 256-coefficient polynomial mod 3329.
// Words arrive on the req_ channel; req_tuser carries the kind: write, start or
// read. A write word stores req_tdata's coefficient at its index as it is
// accepted and gives no result. A read word's index and coefficient reach the
// rsp_ channel through the memory read register, then the result register. A
// start word runs the forward or inverse transform in place, as selected by
// the inverse_mode register (csr index 0); csr index 1 enables the Barrett
// reduction after a forward pass. Each butterfly moves its two words one at a
// time over the single-port memory, through the three-stage multiplier chain
// (Montgomery/Barrett); 896 butterflies precede the per-coefficient pass.
// While a transform runs req_tready stays low. The result register holds a
// word until rsp_tready takes it; writes and starts are still taken meanwhile,
// while a further read waits until the register frees up. Reset clears the
// sequencer and the result valid, and loads inverse_mode 0 and reduction 1;
// the coefficient memory keeps no reset value and must be written first.
// Configuration writes are always ready and are meant to occur while idle.
module kyber_ntt_forward_inverse
   import kntt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] index, [23:8] coefficient
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] index_res, [23:8] coefficient_res
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_data
);

   cmd_type            cmd;
   logic               busy;
   logic [7:0]         rsp_index;
   logic signed [15:0] rsp_coeff;

   assign csr_ready = 1'b1;

   kntt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_index (req_tdata[7:0]),
      .req_ready (req_tready),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .busy      (busy),
      .cmd       (cmd)
   );

   kntt_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_coeff (signed'(req_tdata[23:8])),
      .rsp_index (rsp_index),
      .rsp_coeff (rsp_coeff)
   );

   assign rsp_tdata = {rsp_coeff, rsp_index};

   // The sequencer never takes a new word while a transform runs.
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("word accepted while busy");

   // The memory is never read and written in the same cycle.
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("memory read and write collide");

   // A read result only loads into a free or draining result register.
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

endmodule

// ===== rtl/kntt_dp.sv =====
// Coefficient memory, butterfly arithmetic and the result register.
module kntt_dp
   import kntt_pkg::*;
(
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic signed [15:0] req_coeff,
   output logic [7:0]         rsp_index,
   output logic signed [15:0] rsp_coeff
);

   logic signed [15:0] mem [PolyLength];
   logic signed [15:0] rd_data_ff;
   logic [7:0]         last_addr_ff;
   logic signed [15:0] a_ff, b_ff;
   logic signed [31:0] p_ff, p_in;
   logic [15:0]        m_ff, m_in;
   logic signed [15:0] r_ff, r_in;
   logic signed [32:0] bx_ff, bx_in;
   logic signed [6:0]  bt_ff;
   logic signed [15:0] bres_ff, bres_in;
   logic [7:0]         rsp_index_ff;
   logic signed [15:0] rsp_coeff_ff;

   logic signed [15:0] mont_x, zeta, wr_data;
   logic signed [16:0] bsum;
   logic [31:0]        mq;
   logic signed [31:0] tq, d, btq, bdiff;

   always_comb begin
      case (cmd.op)
         OP_FWD:  mont_x = b_ff;
         OP_INV:  mont_x = b_ff - a_ff;
         default: mont_x = a_ff;
      endcase
      zeta   = (cmd.op == OP_SCL) ? INV_SCALE : TWIDDLE[cmd.rom_idx];
      p_in   = 32'(mont_x) * 32'(zeta);
      bsum   = (cmd.op == OP_INV) ? (17'(a_ff) + 17'(b_ff)) : 17'(a_ff);
      bx_in  = BARRETT_V * 33'(bsum) + BARRETT_ROUND;
      mq     = {16'd0, p_ff[15:0]} * MOD_QINV;
      m_in   = mq[15:0];
      tq     = 32'(signed'(m_ff)) * MOD_Q;
      d      = p_ff - tq;
      r_in   = d[31:16];
      btq    = 32'(bt_ff) * MOD_Q;
      bdiff  = 32'(bsum) - btq;
      bres_in = bdiff[15:0];
      case (cmd.wsel)
         WS_SUM:  wr_data = a_ff + r_ff;
         WS_DIFF: wr_data = a_ff - r_ff;
         WS_BAR:  wr_data = bres_ff;
         WS_MONT: wr_data = r_ff;
         default: wr_data = req_coeff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff   <= mem[cmd.rd_addr];
         last_addr_ff <= cmd.rd_addr;
      end
      if (cmd.cap_a) a_ff <= rd_data_ff;
      if (cmd.cap_b) b_ff <= rd_data_ff;
      if (cmd.step1) begin
         p_ff  <= p_in;
         bx_ff <= bx_in;
      end
      if (cmd.step2) begin
         m_ff  <= m_in;
         bt_ff <= bx_ff[32:26];
      end
      if (cmd.step3) begin
         r_ff    <= r_in;
         bres_ff <= bres_in;
      end
      if (cmd.rsp_load) begin
         rsp_index_ff <= last_addr_ff;
         rsp_coeff_ff <= rd_data_ff;
      end
   end

   assign rsp_index = rsp_index_ff;
   assign rsp_coeff = rsp_coeff_ff;

endmodule

// ===== rtl/kntt_ctrl.sv =====
// Sequencer: item decode, configuration registers and the transform loops.
module kntt_ctrl
   import kntt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_index,
   output logic       req_ready,
   input  logic       csr_valid,
   input  logic [1:0] csr_index,
   input  logic       csr_data,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic       busy,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_RD_OUT = 10'b0000000010,
      S_RD_A   = 10'b0000000100,
      S_RD_B   = 10'b0000001000,
      S_CAP_B  = 10'b0000010000,
      S_MUL1   = 10'b0000100000,
      S_MUL2   = 10'b0001000000,
      S_MUL3   = 10'b0010000000,
      S_WR1    = 10'b0100000000,
      S_WR2    = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       inv_mode_ff, inv_mode_in;
   logic       red_fwd_ff, red_fwd_in;
   logic       inv_ff, inv_in;
   logic       red_ff, red_in;
   logic [2:0] lay_ff, lay_in;
   logic [6:0] bf_ff, bf_in;
   logic [7:0] fin_ff, fin_in;
   logic       fin_pass_ff, fin_pass_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept;
   logic [7:0] bf8, lo_mask, j_addr, hi_addr, lo_addr, up_addr, k_inv;
   logic [6:0] grp, k_fwd;
   logic       last_layer;

   assign req_ready = (state_ff == S_IDLE) &&
                      (req_kind != KIND_READ || !rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      // Butterfly j inserts a zero bit at position lay into the butterfly count.
      bf8     = {1'b0, bf_ff};
      lo_mask = (8'd1 << lay_ff) - 8'd1;
      j_addr  = ((bf8 >> lay_ff) << (4'(lay_ff) + 4'd1)) | (bf8 & lo_mask);
      hi_addr = j_addr | (8'd1 << lay_ff);
      grp     = bf_ff >> lay_ff;
      k_fwd   = (7'd1 << (3'd7 - lay_ff)) + grp;
      k_inv   = (8'd1 << (4'd8 - 4'(lay_ff))) - 8'd1 - {1'b0, grp};
      lo_addr = fin_pass_ff ? fin_ff : j_addr;
      up_addr = fin_pass_ff ? fin_ff : hi_addr;
      last_layer = inv_ff ? (lay_ff == 3'd7) : (lay_ff == 3'd1);
   end

   always_comb begin
      state_in     = state_ff;
      inv_mode_in  = inv_mode_ff;
      red_fwd_in   = red_fwd_ff;
      inv_in       = inv_ff;
      red_in       = red_ff;
      lay_in       = lay_ff;
      bf_in        = bf_ff;
      fin_in       = fin_ff;
      fin_pass_in  = fin_pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd          = '0;
      cmd.wsel     = WS_REQ;
      cmd.rom_idx  = inv_ff ? k_inv[6:0] : k_fwd;
      if (fin_pass_ff) begin
         cmd.op = inv_ff ? OP_SCL : OP_RED;
      end else begin
         cmd.op = inv_ff ? OP_INV : OP_FWD;
      end

      if (csr_valid) begin
         if (csr_index == CSR_INVERSE_MODE) inv_mode_in = csr_data;
         if (csr_index == CSR_REDUCE_FWD)   red_fwd_in  = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_WRITE: begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = req_index;
                  end
                  KIND_READ: begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = req_index;
                     state_in    = S_RD_OUT;
                  end
                  KIND_START: begin
                     inv_in      = inv_mode_ff;
                     red_in      = red_fwd_ff;
                     lay_in      = inv_mode_ff ? 3'd1 : 3'd7;
                     bf_in       = '0;
                     fin_in      = '0;
                     fin_pass_in = 1'b0;
                     state_in    = S_RD_A;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_OUT: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_RD_A: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = lo_addr;
            state_in    = S_RD_B;
         end
         S_RD_B: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = up_addr;
            cmd.cap_a   = 1'b1;
            state_in    = S_CAP_B;
         end
         S_CAP_B: begin
            cmd.cap_b = 1'b1;
            state_in  = S_MUL1;
         end
         S_MUL1: begin
            cmd.step1 = 1'b1;
            state_in  = S_MUL2;
         end
         S_MUL2: begin
            cmd.step2 = 1'b1;
            state_in  = S_MUL3;
         end
         S_MUL3: begin
            cmd.step3 = 1'b1;
            state_in  = S_WR1;
         end
         S_WR1: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = lo_addr;
            if (fin_pass_ff) begin
               cmd.wsel = inv_ff ? WS_MONT : WS_BAR;
               if (fin_ff == 8'd255) begin
                  state_in = S_IDLE;
               end else begin
                  fin_in   = fin_ff + 8'd1;
                  state_in = S_RD_A;
               end
            end else begin
               cmd.wsel = inv_ff ? WS_BAR : WS_SUM;
               state_in = S_WR2;
            end
         end
         S_WR2: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = up_addr;
            cmd.wsel    = inv_ff ? WS_MONT : WS_DIFF;
            bf_in       = bf_ff + 7'd1;
            state_in    = S_RD_A;
            if (bf_ff == 7'd127) begin
               if (last_layer) begin
                  if (inv_ff || red_ff) begin
                     fin_pass_in = 1'b1;
                     fin_in      = '0;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  lay_in = inv_ff ? lay_ff + 3'd1 : lay_ff - 3'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inv_mode_ff  <= 1'b0;
         red_fwd_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         fin_pass_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inv_mode_ff  <= inv_mode_in;
         red_fwd_ff   <= red_fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_pass_ff  <= fin_pass_in;
      end
   end

   always_ff @(posedge clock) begin
      inv_ff <= inv_in;
      red_ff <= red_in;
      lay_ff <= lay_in;
      bf_ff  <= bf_in;
      fin_ff <= fin_in;
   end

endmodule

// ===== sim/tb_kyber_ntt_forward_inverse.sv =====
`timescale 1ns / 1ps

module tb_kyber_ntt_forward_inverse;
   import kntt_pkg::*;

   // Kind code that the block has to drop without a result.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // The settle wait and the watchdog are sized to outlast a whole transform.
   localparam int TransformCycles = 10000;
   localparam int WatchdogLimit   = 60000;
   localparam int HoldOffCycles   = 400;
   localparam int HoldOffAtResult = 150;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  index;
      logic [15:0] coef;
   } word_type;

   typedef struct {
      logic [7:0]  index;
      logic [15:0] coef;
   } read_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic        csr_data;

   kyber_ntt_forward_inverse dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Words waiting to be sent, and read results the block still owes us.
   word_type        pending_words[$];
   read_result_type owed_reads[$];

   // Our own copy of the polynomial store and the two registers.
   logic [15:0] poly_store [PolyLength];
   logic        inv_sel;
   logic        reduce_sel;

   int errors;
   int results_seen;
   int idle_cycles;
   bit req_took;
   bit rsp_took;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Modular arithmetic of the transform, at the widths the block uses.
   // ------------------------------------------------------------------

   // Montgomery reduction with R = 2^16: returns the upper half of
   // a - (a * qinv mod 2^16, sign-extended) * q.
   function automatic logic [15:0] mont_fold(input logic signed [31:0] a);
      logic [31:0]        lo_prod;
      logic signed [31:0] m;
      logic [31:0]        diff;
      lo_prod = ({16'd0, a[15:0]} * MOD_QINV) & 32'h0000_FFFF;
      m       = $signed(lo_prod[15:0]) * MOD_Q;
      diff    = a - m;
      return diff[31:16];
   endfunction

   function automatic logic [15:0] mont_times(input logic [15:0] a, input int b);
      return mont_fold($signed(a) * b);
   endfunction

   // Barrett reduction; the arithmetic shift gives the floor division.
   function automatic logic [15:0] barrett_fold(input int a);
      longint x;
      longint quo;
      int     r;
      x   = 64'sd20159 * a + (64'sd1 << 25);
      quo = x >>> 26;
      r   = a - int'(quo) * 3329;
      return r[15:0];
   endfunction

   task automatic forward_pass();
      int k;
      int z;
      logic [15:0] t;
      logic [15:0] a;
      k = 1;
      for (int len = 128; len >= 2; len = len / 2) begin
         for (int s = 0; s < PolyLength; s += 2 * len) begin
            z = TWIDDLE[k & 127];
            k++;
            for (int j = s; j < s + len; j++) begin
               t = mont_times(poly_store[j + len], z);
               a = poly_store[j];
               poly_store[j + len] = a - t;
               poly_store[j]       = a + t;
            end
         end
      end
      if (reduce_sel)
         for (int j = 0; j < PolyLength; j++)
            poly_store[j] = barrett_fold($signed(poly_store[j]));
   endtask

   task automatic inverse_pass();
      int k;
      int z;
      logic [15:0] a;
      logic [15:0] b;
      k = 127;
      for (int len = 2; len <= 128; len = len * 2) begin
         for (int s = 0; s < PolyLength; s += 2 * len) begin
            z = TWIDDLE[k & 127];
            k--;
            for (int j = s; j < s + len; j++) begin
               a = poly_store[j];
               b = poly_store[j + len];
               // The sum is taken at full width before the Barrett step.
               poly_store[j]       = barrett_fold(int'($signed(a)) + int'($signed(b)));
               poly_store[j + len] = mont_times(b - a, z);
            end
         end
      end
      for (int j = 0; j < PolyLength; j++)
         poly_store[j] = mont_times(poly_store[j], INV_SCALE);
   endtask

   // Applies one accepted word to the store and queues a result for reads.
   task automatic apply_word(input logic [1:0] kind, input logic [7:0] idx,
                             input logic [15:0] coef);
      read_result_type r;
      case (kind)
         KIND_WRITE: begin
            poly_store[idx] = coef;
         end
         KIND_START: begin
            if (inv_sel) inverse_pass();
            else forward_pass();
         end
         KIND_READ: begin
            r.index = idx;
            r.coef  = poly_store[idx];
            owed_reads.push_back(r);
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Request driver: words change at the falling edge. A gap drawn with
   // each word is spent before the next one; now and then a burst mode
   // sends back to back.
   // ------------------------------------------------------------------
   int  req_gap;
   bit  req_burst;
   word_type cur_word;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    = 0;
         req_took   = 1'b0;
      end else if (!req_tvalid || req_took) begin
         req_took = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            cur_word = pending_words.pop_front();
            req_tuser  <= cur_word.kind;
            req_tdata  <= {cur_word.coef, cur_word.index};
            req_tvalid <= 1'b1;
            if ($urandom_range(31) == 0) req_burst = ~req_burst;
            req_gap = req_burst ? 0 : $urandom_range(18);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result ready: a stall is drawn after each result. One long hold-off
   // lets the result register stay full so the block has to stall its input.
   int  rsp_stall;
   bit  rsp_burst;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  = 0;
         rsp_took   = 1'b0;
      end else begin
         if (rsp_took) begin
            rsp_took = 1'b0;
            if ($urandom_range(23) == 0) rsp_burst = ~rsp_burst;
            if (results_seen == HoldOffAtResult) rsp_stall = HoldOffCycles;
            else rsp_stall = rsp_burst ? 0 : $urandom_range(18);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. Accepted requests
   // feed the predictor, accepted results are checked against the oldest
   // owed read.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      read_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_word(req_tuser, req_tdata[7:0], req_tdata[23:8]);
            req_took = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_took = 1'b1;
            results_seen++;
            if (owed_reads.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual index %0d coef %0d",
                        $time, rsp_tdata[7:0], $signed(rsp_tdata[23:8]));
            end else begin
               want = owed_reads.pop_front();
               if (rsp_tdata[7:0] !== want.index) begin
                  errors++;
                  $display("%0t: index_res mismatch: expected %0d, actual %0d",
                           $time, want.index, rsp_tdata[7:0]);
               end
               if (rsp_tdata[23:8] !== want.coef) begin
                  errors++;
                  $display("%0t: coefficient_res mismatch at %0d: expected %0d, actual %0d",
                           $time, want.index, $signed(want.coef),
                           $signed(rsp_tdata[23:8]));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_INVERSE_MODE) inv_sel = csr_data;
            else if (csr_index == CSR_REDUCE_FWD) reduce_sel = csr_data;
         end
      end
   end

   // Watchdog: a long run of cycles with no word moving on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   task automatic push_word(input logic [1:0] kind, input logic [7:0] idx,
                            input logic [15:0] coef);
      word_type w;
      w.kind  = kind;
      w.index = idx;
      w.coef  = coef;
      pending_words.push_back(w);
   endtask

   // Waits until every queued word went out and every read came back, then
   // lets a possible trailing transform finish.
   task automatic settle();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_tvalid || owed_reads.size() != 0);
      repeat (TransformCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic val);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random mix of writes, reads and dropped words around one transform.
   task automatic random_phase(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) push_word(KIND_START, 8'($urandom), 16'($urandom));
         pick = $urandom_range(99);
         if (pick < 40)
            push_word(KIND_WRITE, 8'($urandom), 16'($urandom));
         else if (pick < 95)
            push_word(KIND_READ, 8'($urandom), 16'($urandom));
         else
            push_word(KIND_UNUSED, 8'($urandom), 16'($urandom));
      end
   endtask

   // Each row is one register setting: inverse_mode, reduce_after_forward.
   logic [1:0] phase_cfg [6] = '{2'b01, 2'b00, 2'b10, 2'b11, 2'b00, 2'b10};

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_WRITE;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_INVERSE_MODE;
      csr_data   = 1'b0;
      errors       = 0;
      results_seen = 0;
      idle_cycles  = 0;
      inv_sel      = 1'b0;
      reduce_sel   = 1'b1;
      req_burst    = 1'b0;
      rsp_burst    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: fill the whole store first, since no entry may be
      // read or transformed before it was written. The corners of the
      // coefficient range sit at the ends of the polynomial.
      for (int i = 0; i < PolyLength; i++) begin
         case (i)
            0:       push_word(KIND_WRITE, 8'(i), 16'h8000);
            1:       push_word(KIND_WRITE, 8'(i), 16'h0000);
            2:       push_word(KIND_WRITE, 8'(i), 16'hFFFF);
            255:     push_word(KIND_WRITE, 8'(i), 16'h7FFF);
            default: push_word(KIND_WRITE, 8'(i), 16'($urandom));
         endcase
      end
      push_word(KIND_READ, 8'd0, 16'hFFFF);
      push_word(KIND_READ, 8'd255, 16'h0000);
      push_word(KIND_UNUSED, 8'hFF, 16'hFFFF);
      // Forward transform with the reset register values.
      push_word(KIND_START, 8'h00, 16'h0000);
      push_word(KIND_READ, 8'd0, 16'h0000);
      push_word(KIND_READ, 8'd1, 16'h0000);
      push_word(KIND_READ, 8'd128, 16'h0000);
      push_word(KIND_READ, 8'd255, 16'h0000);
      settle();

      // Random phases, each under its own register setting.
      foreach (phase_cfg[p]) begin
         write_reg(CSR_INVERSE_MODE, phase_cfg[p][1]);
         write_reg(CSR_REDUCE_FWD, phase_cfg[p][0]);
         random_phase(110);
         settle();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && owed_reads.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/kntt_pkg.sv
rtl/kntt_dp.sv
rtl/kntt_ctrl.sv
rtl/kyber_ntt_forward_inverse.sv
sim/tb_kyber_ntt_forward_inverse.sv
